/* hdl/utf8d_pkg.sv */
// Package for the UTF-8 to code point decoder.
// Holds field widths, byte class masks, state types and a byte widening function.
// No dependencies.
package utf8d_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CP_WIDTH   = 21;
   localparam int CNT_WIDTH  = 2;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [CP_WIDTH-1:0]   cp_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;

   // Byte classes: a byte belongs to a class when (byte & MASK) == CODE.
   localparam byte_type ASCII_MASK = 8'h80;
   localparam byte_type ASCII_CODE = 8'h00;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_CODE = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_CODE = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_CODE = 8'hF0;
   localparam byte_type CONT_MASK  = 8'hC0;
   localparam byte_type CONT_CODE  = 8'h80;

   // Payload masks for the lead and continuation byte classes.
   localparam byte_type LEAD2_BITS = 8'h1F;
   localparam byte_type LEAD3_BITS = 8'h0F;
   localparam byte_type LEAD4_BITS = 8'h07;
   localparam byte_type CONT_BITS  = 8'h3F;
   localparam int       CONT_SHIFT = 6;

   localparam cnt_type CNT_NONE  = 2'd0;
   localparam cnt_type CNT_ONE   = 2'd1;
   localparam cnt_type CNT_TWO   = 2'd2;
   localparam cnt_type CNT_THREE = 2'd3;

   typedef struct packed {
      cp_type  partial;
      cnt_type remaining;
   } dec_state_type;

   typedef struct packed {
      logic   emit;
      cp_type value;
   } dec_result_type;

   // Widen one byte into code point width.
   function automatic cp_type widen(input byte_type b);
      return {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, b};
   endfunction

endpackage

/* hdl/utf8_to_code_point_decoder_core.sv */
// Top level of the UTF-8 to code point decoder.
// Depends on utf8d_pkg for widths, byte class masks and state types.
//
// The decoder takes one UTF-8 byte per request and returns a 21-bit code
// point when a sequence completes, when the byte flagged as end of text cuts
// a sequence short (its partial value is returned), or for a nonzero ASCII
// byte. Invalid lead bytes are skipped, a bad continuation byte drops the
// pending value, and a zero value is never returned. Each byte is decoded in
// a single pass from the request port into the result register, so the block
// takes one byte every cycle and offers its result in the cycle after the
// byte is taken; it holds off a request only while the result register is
// full and the result side is not taking it.
module utf8_to_code_point_decoder_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  utf8d_pkg::byte_type       req_text_byte,
   input  logic                      req_end_of_text,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output utf8d_pkg::cp_type         rsp_code_point,
   output logic                      rsp_from_last_byte
);
   import utf8d_pkg::*;

   dec_state_type  state_ff, state_in;
   dec_result_type result;
   cp_type         shifted;
   logic           req_accept;

   logic   rsp_valid_ff, rsp_valid_in;
   cp_type rsp_code_point_ff;
   logic   rsp_last_ff;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign shifted = {state_ff.partial[CP_WIDTH-CONT_SHIFT-1:0],
                     req_text_byte[CONT_SHIFT-1:0]};

   always_comb begin
      state_in     = state_ff;
      result.emit  = 1'b0;
      result.value = '0;
      if (state_ff.remaining == CNT_NONE) begin
         if ((req_text_byte & ASCII_MASK) == ASCII_CODE) begin
            result.emit  = 1'b1;
            result.value = widen(req_text_byte);
         end else if ((req_text_byte & LEAD2_MASK) == LEAD2_CODE) begin
            state_in.partial   = widen(req_text_byte & LEAD2_BITS);
            state_in.remaining = CNT_ONE;
         end else if ((req_text_byte & LEAD3_MASK) == LEAD3_CODE) begin
            state_in.partial   = widen(req_text_byte & LEAD3_BITS);
            state_in.remaining = CNT_TWO;
         end else if ((req_text_byte & LEAD4_MASK) == LEAD4_CODE) begin
            state_in.partial   = widen(req_text_byte & LEAD4_BITS);
            state_in.remaining = CNT_THREE;
         end
      end else if ((req_text_byte & CONT_MASK) != CONT_CODE) begin
         // A pending sequence is abandoned; the byte is not a new lead.
         state_in.partial   = '0;
         state_in.remaining = CNT_NONE;
      end else begin
         state_in.partial   = shifted;
         state_in.remaining = state_ff.remaining - CNT_ONE;
         if (state_in.remaining == CNT_NONE) begin
            result.emit      = 1'b1;
            result.value     = shifted;
            state_in.partial = '0;
         end
      end
      // The last byte of the text flushes whatever is still pending.
      if (req_end_of_text) begin
         if (state_in.remaining != CNT_NONE) begin
            result.emit  = 1'b1;
            result.value = state_in.partial;
         end
         state_in.partial   = '0;
         state_in.remaining = CNT_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept && result.emit && (result.value != '0)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.partial   <= '0;
         state_ff.remaining <= CNT_NONE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result.emit && (result.value != '0)) begin
         rsp_code_point_ff <= result.value;
         rsp_last_ff       <= req_end_of_text;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_point     = rsp_code_point_ff;
   assign rsp_from_last_byte = rsp_last_ff;

   // A held result is never a zero code point.
   a_no_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_code_point_ff != '0))
      else $error("decoder result register holds a zero code point");

   // With no continuation bytes expected, no partial value is kept.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.remaining == CNT_NONE) |-> (state_ff.partial == '0))
      else $error("decoder idle with a partial value left over");

   // The end of the text always leaves the decoder idle.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_of_text) |=>
         ((state_ff.remaining == CNT_NONE) && (state_ff.partial == '0)))
      else $error("decoder state not cleared after end of text");

   // A nonzero ASCII byte taken while idle comes out as itself next cycle.
   a_ascii_pass: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (state_ff.remaining == CNT_NONE) && !req_text_byte[BYTE_WIDTH-1]
         && (req_text_byte != '0)) |=>
         (rsp_valid_ff && (rsp_code_point_ff == widen($past(req_text_byte)))))
      else $error("decoder lost or altered an ASCII byte");

endmodule

/* verif/utf8_decoder_checker.sv */
// Checker for the UTF-8 to code point decoder: watches both channels,
// predicts code points from accepted bytes and compares returned results.
// Depends on utf8d_pkg for widths and byte class masks.
module utf8_decoder_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  utf8d_pkg::byte_type req_text_byte,
   input  logic                req_end_of_text,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  utf8d_pkg::cp_type   rsp_code_point,
   input  logic                rsp_from_last_byte,
   output int                  mismatch_count,
   output int                  code_points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import utf8d_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      cp_type code_point;
      logic   from_last_byte;
   } code_point_entry_type;

   code_point_entry_type expected_code_points[$];

   // Shadow copy of the decoder's pending sequence.
   cp_type  shadow_value;
   cnt_type shadow_remaining;

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   // Advances the shadow state by one byte; returns 1 when a nonzero code point is due.
   function automatic logic decode_text_byte(input byte_type b, input logic last,
                                             output cp_type code_point);
      logic   due;
      cp_type value;
      due = 1'b0;
      value = '0;
      if (shadow_remaining == CNT_NONE) begin
         if ((b & ASCII_MASK) == ASCII_CODE) begin
            value = cp_type'(b);
            due = 1'b1;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            shadow_value = cp_type'(b & LEAD2_BITS);
            shadow_remaining = CNT_ONE;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            shadow_value = cp_type'(b & LEAD3_BITS);
            shadow_remaining = CNT_TWO;
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            shadow_value = cp_type'(b & LEAD4_BITS);
            shadow_remaining = CNT_THREE;
         end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
         // A broken sequence swallows the offending byte.
         shadow_value = '0;
         shadow_remaining = CNT_NONE;
      end else begin
         shadow_value = cp_type'((shadow_value << CONT_SHIFT) | cp_type'(b & CONT_BITS));
         shadow_remaining = shadow_remaining - CNT_ONE;
         if (shadow_remaining == CNT_NONE) begin
            value = shadow_value;
            due = 1'b1;
            shadow_value = '0;
         end
      end
      if (last) begin
         // A sequence cut short by the end of the text returns what it has.
         if (shadow_remaining != CNT_NONE) begin
            value = shadow_value;
            due = 1'b1;
         end
         shadow_value = '0;
         shadow_remaining = CNT_NONE;
      end
      code_point = value;
      return due && (value != '0);
   endfunction

   always @(posedge clock) begin
      code_point_entry_type oldest;
      code_point_entry_type fresh;
      cp_type predicted;
      if (reset) begin
         expected_code_points.delete();
         shadow_value = '0;
         shadow_remaining = CNT_NONE;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_code_points.size() == 0) begin
               note_mismatch($sformatf("unexpected result code_point=%h from_last_byte=%0b",
                                       rsp_code_point, rsp_from_last_byte));
            end else begin
               oldest = expected_code_points.pop_front();
               if (oldest.code_point !== rsp_code_point ||
                   oldest.from_last_byte !== rsp_from_last_byte)
                  note_mismatch($sformatf(
                     "code_point exp %h got %h, from_last_byte exp %0b got %0b",
                     oldest.code_point, rsp_code_point,
                     oldest.from_last_byte, rsp_from_last_byte));
            end
         end
         if (req_valid && req_ready &&
             decode_text_byte(req_text_byte, req_end_of_text, predicted)) begin
            fresh = {predicted, req_end_of_text};
            expected_code_points = {expected_code_points, fresh};
         end
      end
      code_points_pending = expected_code_points.size();
   end

endmodule

/* verif/utf8_to_code_point_decoder_core_tb.sv */
// Testbench top for the UTF-8 to code point decoder: drives byte requests and
// result backpressure, and gives the verdict.
// Depends on utf8d_pkg, utf8_to_code_point_decoder_core and utf8_decoder_checker.
module utf8_to_code_point_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8d_pkg::*;

   localparam int TOTAL_BYTES     = 725;
   localparam int QUIET_FROM      = 250;
   localparam int QUIET_TO        = 400;
   localparam int DRAIN_AT        = 350;
   localparam int HOLD_OFF_AT     = 550;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_PERCENT    = 7;
   localparam int LAST_PERCENT    = 3;
   localparam int DRAIN_CYCLES    = 20;
   localparam int LIMIT_CYCLES    = 100000;

   // Directed bytes, {end_of_text, text_byte}.
   localparam logic [8:0] DIRECTED_BYTES[25] = '{
      9'h041, 9'h07F, 9'h000,                 // an ASCII letter, the largest ASCII byte and the zero byte
      9'h0C3, 9'h0A9,                         // two-byte sequence
      9'h0E2, 9'h082, 9'h0AC,                 // three-byte sequence
      9'h0F0, 9'h09F, 9'h098, 9'h080,         // four-byte sequence
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // largest four-byte value
      9'h080, 9'h0F8, 9'h0FF,                 // stray continuation and bad leads
      9'h0C3, 9'h041,                         // broken sequence
      9'h0E2, 9'h182,                         // sequence cut short by end of text
      9'h1C5,                                 // lead as the last byte
      9'h1C0                                  // cut short with a zero partial value
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_text_byte = '0;
   logic     req_end_of_text = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   cp_type   rsp_code_point;
   logic     rsp_from_last_byte;

   int mismatch_count;
   int code_points_pending;
   int bytes_sent = 0;
   bit quiet_stretch = 1'b0;
   bit hold_off_request = 1'b0;

   utf8_to_code_point_decoder_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_from_last_byte (rsp_from_last_byte)
   );

   utf8_decoder_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_end_of_text     (req_end_of_text),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_code_point      (rsp_code_point),
      .rsp_from_last_byte  (rsp_from_last_byte),
      .mismatch_count      (mismatch_count),
      .code_points_pending (code_points_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: random backpressure, plus one long hold-off on demand.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_byte(input byte_type b, input logic last);
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   function automatic byte_type continuation_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // Mostly well-formed sequences with random payload; the rest broken or noise.
   task automatic send_random_sequence();
      byte_type text[$];
      byte_type b;
      int kind;
      int length;
      kind = $urandom_range(99);
      length = $urandom_range(1, 3);
      if (kind < 20) begin
         text = {text, byte_type'({1'b0, 7'($urandom)})};
      end else if (kind < 75) begin
         length = (kind < 40) ? 1 : (kind < 60) ? 2 : 3;
         case (length)
            1: text = {text, byte_type'({3'b110, 5'($urandom)})};
            2: text = {text, byte_type'({4'b1110, 4'($urandom)})};
            default: text = {text, byte_type'({5'b11110, 3'($urandom)})};
         endcase
         repeat (length) text = {text, continuation_byte()};
      end else if (kind < 87) begin
         case (length)
            1: text = {text, byte_type'({3'b110, 5'($urandom)})};
            2: text = {text, byte_type'({4'b1110, 4'($urandom)})};
            default: text = {text, byte_type'({5'b11110, 3'($urandom)})};
         endcase
         repeat ($urandom_range(0, length - 1)) text = {text, continuation_byte()};
         b = 8'($urandom);
         if (b[7:6] == 2'b10)
            b[6] = 1'b1;
         text = {text, b};
      end else begin
         text = {text, byte_type'(8'($urandom))};
      end
      foreach (text[i])
         send_byte(text[i], $urandom_range(99) < LAST_PERCENT);
   endtask

   initial begin
      bit drained;
      bit held;
      drained = 1'b0;
      held = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (code_points_pending == 0);
      @(posedge clock);

      while (bytes_sent < TOTAL_BYTES) begin
         quiet_stretch = (bytes_sent >= QUIET_FROM) && (bytes_sent < QUIET_TO);
         if (!drained && bytes_sent >= DRAIN_AT) begin
            // The sender stops until every expected code point is back.
            drained = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            wait (code_points_pending == 0);
            @(posedge clock);
         end
         if (!held && bytes_sent >= HOLD_OFF_AT) begin
            held = 1'b1;
            hold_off_request = 1'b1;
         end
         send_random_sequence();
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      wait (code_points_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && code_points_pending == 0)
         $display("utf8_to_code_point_decoder_core_tb: PASS");
      else
         $display("utf8_to_code_point_decoder_core_tb: FAIL");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("utf8_to_code_point_decoder_core_tb: FAIL");
      $finish;
   end

endmodule
